// ===== rtl/lsom_pkg.sv =====
// Shared types, constants and angle table for the lidar sector obstacle mapper.
`timescale 1ns / 1ps
`default_nettype none
package lsom_pkg;

	localparam int BYTE_W  = 8;
	localparam int ANGLE_W = 15;
	localparam int DIST_W  = 16;
	localparam int LANE_W  = 4;
	localparam int FLAGS_W = 9;
	localparam int POS_W   = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int ROM_IDX_W  = 6;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL  = 4'd1;

	localparam logic [DIST_W-1:0]  DIST_LIMIT_RST = 16'd80;
	localparam logic [ANGLE_W-1:0] ANGLE_TOL_RST  = 15'd64;

	// Byte positions inside a five byte packet
	localparam logic [POS_W-1:0] POS_QUALITY = 3'd0;
	localparam logic [POS_W-1:0] POS_ANG_LO  = 3'd1;
	localparam logic [POS_W-1:0] POS_ANG_HI  = 3'd2;
	localparam logic [POS_W-1:0] POS_DIST_LO = 3'd3;
	localparam logic [POS_W-1:0] POS_DIST_HI = 3'd4;

	localparam logic [ROM_IDX_W-1:0] ROM_SIZE = 6'd27;

	// Completed packet from the framer
	typedef struct packed {
		logic               done;
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  range_q2;
	} pkt_t;

	// One result beat
	typedef struct packed {
		logic [ANGLE_W-1:0] meas_angle;
		logic [DIST_W-1:0]  distance_q2;
		logic               matched;
		logic [LANE_W-1:0]  lane_number;
		logic [FLAGS_W-1:0] lane_clear_bits;
	} res_t;

	// Expected angle in 1/64 degree; index wraps at the table size
	function automatic logic [ANGLE_W-1:0] rom_angle(input logic [ROM_IDX_W-1:0] idx);
		logic [ROM_IDX_W-1:0] r;
		logic [8:0]           deg;
		r = idx;
		if (r >= ROM_SIZE) r = r - ROM_SIZE;
		if (r >= ROM_SIZE) r = r - ROM_SIZE;
		case (r)
			6'd0:  deg = 9'd275;
			6'd1:  deg = 9'd280;
			6'd2:  deg = 9'd285;
			6'd3:  deg = 9'd295;
			6'd4:  deg = 9'd300;
			6'd5:  deg = 9'd305;
			6'd6:  deg = 9'd315;
			6'd7:  deg = 9'd320;
			6'd8:  deg = 9'd325;
			6'd9:  deg = 9'd335;
			6'd10: deg = 9'd340;
			6'd11: deg = 9'd345;
			6'd12: deg = 9'd355;
			6'd13: deg = 9'd0;
			6'd14: deg = 9'd5;
			6'd15: deg = 9'd15;
			6'd16: deg = 9'd20;
			6'd17: deg = 9'd25;
			6'd18: deg = 9'd35;
			6'd19: deg = 9'd40;
			6'd20: deg = 9'd45;
			6'd21: deg = 9'd55;
			6'd22: deg = 9'd60;
			6'd23: deg = 9'd65;
			6'd24: deg = 9'd75;
			6'd25: deg = 9'd80;
			6'd26: deg = 9'd85;
			default: deg = 9'd0;
		endcase
		return {deg, 6'b000000};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lsom_framer.sv =====
// Packet framer: tracks byte position and assembles angle and distance.
`timescale 1ns / 1ps
`default_nettype none
module lsom_framer
	import lsom_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] data,
	output pkt_t                   pkt
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] ang_lo_q;
	logic [BYTE_W-1:0] ang_hi_q;
	logic [BYTE_W-1:0] dist_lo_q;
	logic [POS_W-1:0]  pos;

	// out-of-range position restarts at the quality byte
	assign pos = (pos_q > POS_DIST_HI) ? POS_QUALITY : pos_q;

	// last byte completes the packet
	always_comb begin
		pkt.done     = (pos == POS_DIST_HI);
		pkt.angle    = {ang_hi_q, ang_lo_q[BYTE_W-1:1]};
		pkt.range_q2 = {data, dist_lo_q};
	end

	// position counter and byte capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_QUALITY;
			ang_lo_q  <= '0;
			ang_hi_q  <= '0;
			dist_lo_q <= '0;
		end else if (step) begin
			pos_q <= (pos >= POS_DIST_HI) ? POS_QUALITY : pos + 3'd1;
			case (pos)
				POS_ANG_LO:  ang_lo_q  <= data;
				POS_ANG_HI:  ang_hi_q  <= data;
				POS_DIST_LO: dist_lo_q <= data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lsom_matcher.sv =====
// Angle matcher: table compare, lane bookkeeping and lane flag update.
`timescale 1ns / 1ps
`default_nettype none
module lsom_matcher
	import lsom_pkg::*;
#(
	parameter int TABLE_ANGLES = 27,
	parameter int LANE_COUNT   = 9
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire pkt_t               pkt,
	input  wire logic [DIST_W-1:0]  dist_limit,
	input  wire logic [ANGLE_W-1:0] angle_tol,
	output res_t                    res
);

	localparam int TP_W = (TABLE_ANGLES > 1) ? $clog2(TABLE_ANGLES) : 1;
	localparam int LP_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
	localparam logic [TP_W-1:0] TP_LAST = TP_W'(TABLE_ANGLES - 1);
	localparam logic [LP_W-1:0] LP_LAST = LP_W'(LANE_COUNT - 1);

	logic [TP_W-1:0]       tp_q;
	logic [1:0]            cnt_q;
	logic [LP_W-1:0]       lane_q;
	logic [LANE_COUNT-1:0] flags_q;

	logic [ANGLE_W-1:0]    expect_q6;
	logic [ANGLE_W-1:0]    diff;
	logic                  hit;
	logic [LANE_COUNT-1:0] flags_nx;

	// absolute angle difference against the expected table angle
	always_comb begin
		expect_q6 = rom_angle(ROM_IDX_W'(tp_q));
		diff      = (expect_q6 >= pkt.angle) ? expect_q6 - pkt.angle
		                                     : pkt.angle - expect_q6;
		hit       = (diff <= angle_tol);
	end

	// lane bit: clear when beyond the distance limit
	always_comb begin
		flags_nx = flags_q;
		if (hit) flags_nx[lane_q] = (pkt.range_q2 > dist_limit);
	end

	always_comb begin
		res.meas_angle      = pkt.angle;
		res.distance_q2     = pkt.range_q2;
		res.matched         = hit;
		res.lane_number     = hit ? LANE_W'(lane_q) : '0;
		res.lane_clear_bits = FLAGS_W'(flags_nx);
	end

	// table index, match count and lane advance on a matched packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q    <= '0;
			cnt_q   <= '0;
			lane_q  <= '0;
			flags_q <= '0;
		end else if (step && pkt.done && hit) begin
			flags_q <= flags_nx;
			tp_q    <= (tp_q == TP_LAST) ? '0 : tp_q + 1'b1;
			if (cnt_q == 2'd2) begin
				cnt_q  <= '0;
				lane_q <= (lane_q == LP_LAST) ? '0 : lane_q + 1'b1;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lidar_sector_obstacle_mapper.sv =====
// Top level of the lidar sector obstacle mapper.
// Usage:
//  - in channel: one stream byte per beat (in_valid/in_ready). Packets are five
//    bytes: quality, angle low, angle high, distance low, distance high.
//  - out channel: one result beat per completed packet, none for other bytes.
//  - cfg channel: cfg_index 0 = distance limit, 1 = angle tolerance; other
//    indexes are ignored. cfg_ready is always high. Write only while idle.
// Timing:
//  - A byte is accepted into the input register; the fifth byte of a packet
//    then moves its result into the result register, which drives out_valid.
//  - Throughput is one byte per cycle while no packet's last byte stalls,
//    set by the single input register and the single result register; byte
//    framing and the table match are combinational between them.
// Stall:
//  - While a result waits, bytes that produce no result keep flowing; a
//    packet's last byte holds in the input register while the result register
//    is full and not being read, and in_ready is low for those cycles.
// Reset:
//  - arst_n clears framing, table index, lane, match count and lane flags;
//    registers return to 80 and 64. No result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module lidar_sector_obstacle_mapper
	import lsom_pkg::*;
#(
	parameter int TABLE_ANGLES = 27,
	parameter int LANE_COUNT   = 9
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [BYTE_W-1:0]     stream_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ANGLE_W-1:0]         meas_angle,
	output logic [DIST_W-1:0]          distance_q2,
	output logic                       matched,
	output logic [LANE_W-1:0]          lane_number,
	output logic [FLAGS_W-1:0]         lane_clear_bits,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [DIST_W-1:0]  dist_limit_q;
	logic [ANGLE_W-1:0] angle_tol_q;
	logic               out_valid_q;
	res_t               res_q;
	pkt_t               pkt;
	res_t               res;
	logic               out_free;
	logic               advance;

	// handshake: a byte leaves s1 when it needs no result slot or one is free
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && (!pkt.done || out_free);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= stream_byte;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_limit_q <= DIST_LIMIT_RST;
			angle_tol_q  <= ANGLE_TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DIST_LIMIT: dist_limit_q <= cfg_data;
				CFG_ANGLE_TOL:  angle_tol_q  <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	lsom_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.pkt    (pkt)
	);

	lsom_matcher #(
		.TABLE_ANGLES (TABLE_ANGLES),
		.LANE_COUNT   (LANE_COUNT)
	) u_matcher (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.pkt        (pkt),
		.dist_limit (dist_limit_q),
		.angle_tol  (angle_tol_q),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && pkt.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pkt.done) res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign meas_angle      = res_q.meas_angle;
	assign distance_q2     = res_q.distance_q2;
	assign matched         = res_q.matched;
	assign lane_number     = res_q.lane_number;
	assign lane_clear_bits = res_q.lane_clear_bits;

endmodule
`default_nettype wire

// ===== rtl/lsom_checker.sv =====
// Port-level checks for the lidar sector obstacle mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lsom_checker
	import lsom_pkg::*;
#(
	parameter int LANE_COUNT = 9
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [ANGLE_W-1:0] meas_angle,
	input wire logic [DIST_W-1:0]  distance_q2,
	input wire logic               matched,
	input wire logic [LANE_W-1:0]  lane_number,
	input wire logic [FLAGS_W-1:0] lane_clear_bits
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(meas_angle)
			&& $stable(distance_q2) && $stable(matched)
			&& $stable(lane_number) && $stable(lane_clear_bits))
		else $error("result beat changed while stalled");

	// unmatched packets report lane zero
	a_unmatched_lane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> lane_number == '0)
		else $error("lane reported on unmatched packet");

	// matched lane stays inside the lane count
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> (LANE_COUNT > 16) || (int'(lane_number) < LANE_COUNT))
		else $error("lane number out of range");

	// no result pending right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result pending after reset");

endmodule

bind lidar_sector_obstacle_mapper lsom_checker #(
	.LANE_COUNT (LANE_COUNT)
) u_lsom_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.meas_angle      (meas_angle),
	.distance_q2     (distance_q2),
	.matched         (matched),
	.lane_number     (lane_number),
	.lane_clear_bits (lane_clear_bits)
);
`default_nettype wire

// ===== tb/sv/lane_map_checker.sv =====
// Checker for the lidar sector obstacle mapper: predicts each packet result and compares beats.
`timescale 1ns / 1ps
module lane_map_checker
	import lsom_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [BYTE_W-1:0]     stream_byte,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [ANGLE_W-1:0]    meas_angle,
	input  wire logic [DIST_W-1:0]     distance_q2,
	input  wire logic                  matched,
	input  wire logic [LANE_W-1:0]     lane_number,
	input  wire logic [FLAGS_W-1:0]    lane_clear_bits,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output logic [ANGLE_W-1:0]         slot_angle,
	output logic [POS_W-1:0]           frame_pos
);

	localparam int SLOTS       = 27;
	localparam int LANES       = 9;
	localparam int HITS_PER_LANE = 3;
	localparam int Q6_SCALE    = 64;

	// expected scan angles in whole degrees, one per table slot
	int unsigned scan_deg [0:SLOTS-1];

	// predicted result beats, oldest first
	res_t packet_reports [$];

	logic [BYTE_W-1:0]  ang_lo;
	logic [BYTE_W-1:0]  ang_hi;
	logic [BYTE_W-1:0]  dist_lo;
	int                 slot;
	int                 hits_in_lane;
	int                 lane;
	logic [FLAGS_W-1:0] clear_bits;
	logic [DIST_W-1:0]  dist_limit;
	logic [ANGLE_W-1:0] angle_tol;

	initial begin
		scan_deg = '{275, 280, 285, 295, 300, 305, 315, 320, 325, 335, 340, 345, 355, 0,
			5, 15, 20, 25, 35, 40, 45, 55, 60, 65, 75, 80, 85};
	end

	// frame one stream byte; the last byte of a packet yields a result
	task automatic map_byte(input logic [BYTE_W-1:0] b);
		logic [POS_W-1:0] pos;
		res_t             r;
		int               target;
		int               diff;
		pos = (frame_pos > POS_DIST_HI) ? POS_QUALITY : frame_pos;
		frame_pos = (pos == POS_DIST_HI) ? POS_QUALITY : pos + 1'b1;
		case (pos)
			POS_ANG_LO:  ang_lo = b;
			POS_ANG_HI:  ang_hi = b;
			POS_DIST_LO: dist_lo = b;
			POS_DIST_HI: begin
				// check bit of the low angle byte is dropped
				r.meas_angle  = {ang_hi, ang_lo[7:1]};
				r.distance_q2 = {b, dist_lo};
				target = int'(scan_deg[slot]) * Q6_SCALE;
				diff   = target - int'(r.meas_angle);
				if (diff < 0) diff = -diff;
				r.matched     = (diff <= int'(angle_tol));
				r.lane_number = '0;
				if (r.matched) begin
					// clear only when strictly beyond the limit
					clear_bits[lane] = (r.distance_q2 > dist_limit);
					r.lane_number = lane[LANE_W-1:0];
					slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
					hits_in_lane++;
					if (hits_in_lane >= HITS_PER_LANE) begin
						hits_in_lane = 0;
						lane = (lane + 1 >= LANES) ? 0 : lane + 1;
					end
				end
				r.lane_clear_bits = clear_bits;
				packet_reports.push_back(r);
			end
			default: ;
		endcase
	endtask

	// compare one result beat with the oldest prediction
	task automatic check_beat();
		res_t want;
		if (packet_reports.size() == 0) begin
			$display("%0t: result beat with none expected: angle %0d dist %0d", $time,
				meas_angle, distance_q2);
			fail_count++;
		end else begin
			want = packet_reports.pop_front();
			if (meas_angle !== want.meas_angle) begin
				$display("%0t: meas_angle expected %0d, got %0d", $time, want.meas_angle,
					meas_angle);
				fail_count++;
			end
			if (distance_q2 !== want.distance_q2) begin
				$display("%0t: distance_q2 expected %0d, got %0d", $time, want.distance_q2,
					distance_q2);
				fail_count++;
			end
			if (matched !== want.matched) begin
				$display("%0t: matched expected %0b, got %0b", $time, want.matched, matched);
				fail_count++;
			end
			if (lane_number !== want.lane_number) begin
				$display("%0t: lane_number expected %0d, got %0d", $time, want.lane_number,
					lane_number);
				fail_count++;
			end
			if (lane_clear_bits !== want.lane_clear_bits) begin
				$display("%0t: lane_clear_bits expected %b, got %b", $time,
					want.lane_clear_bits, lane_clear_bits);
				fail_count++;
			end
		end
	endtask

	// watch all three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos    = POS_QUALITY;
			ang_lo       = '0;
			ang_hi       = '0;
			dist_lo      = '0;
			slot         = 0;
			hits_in_lane = 0;
			lane         = 0;
			clear_bits   = '0;
			dist_limit   = DIST_LIMIT_RST;
			angle_tol    = ANGLE_TOL_RST;
			fail_count   = 0;
			packet_reports.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DIST_LIMIT: dist_limit = cfg_data;
					CFG_ANGLE_TOL:  angle_tol = cfg_data[ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) check_beat();
			if (in_valid && in_ready) map_byte(stream_byte);
		end
		pending    = packet_reports.size();
		slot_angle = ANGLE_W'(int'(scan_deg[slot]) * Q6_SCALE);
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench: clock, reset, packet stimulus, register writes and the verdict.
`timescale 1ns / 1ps
module testbench;
	import lsom_pkg::*;

	localparam int STALL_PCT      = 14;
	localparam int PHASES         = 8;
	localparam int PHASE_BYTES    = 130;
	localparam int CALM_PHASE     = 5;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ANGLE_MAX      = 32767;
	localparam int DIST_MAX       = 65535;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [BYTE_W-1:0]     stream_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [ANGLE_W-1:0]    meas_angle;
	logic [DIST_W-1:0]     distance_q2;
	logic                  matched;
	logic [LANE_W-1:0]     lane_number;
	logic [FLAGS_W-1:0]    lane_clear_bits;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int                 fail_count;
	int                 pending;
	logic [ANGLE_W-1:0] slot_angle;
	logic [POS_W-1:0]   frame_pos;

	// no idling on either side while set
	logic               calm;
	logic [DIST_W-1:0]  cur_limit;
	logic [ANGLE_W-1:0] cur_tol;
	int                 bytes_sent;
	int                 quiet_cycles = 0;

	lidar_sector_obstacle_mapper u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.stream_byte     (stream_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.meas_angle      (meas_angle),
		.distance_q2     (distance_q2),
		.matched         (matched),
		.lane_number     (lane_number),
		.lane_clear_bits (lane_clear_bits),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	lane_map_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.stream_byte     (stream_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.meas_angle      (meas_angle),
		.distance_q2     (distance_q2),
		.matched         (matched),
		.lane_number     (lane_number),
		.lane_clear_bits (lane_clear_bits),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.slot_angle      (slot_angle),
		.frame_pos       (frame_pos)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side backpressure
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// end the run when no channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// one byte beat, with random idle cycles ahead of it; returns on a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// realign to a packet start, then send a five byte packet
	task automatic send_packet(input int angle, input int dist_val);
		logic [ANGLE_W-1:0] a;
		logic [DIST_W-1:0]  d;
		if (angle < 0) angle = 0;
		if (angle > ANGLE_MAX) angle = ANGLE_MAX;
		if (dist_val < 0) dist_val = 0;
		if (dist_val > DIST_MAX) dist_val = DIST_MAX;
		a = angle[ANGLE_W-1:0];
		d = dist_val[DIST_W-1:0];
		while (frame_pos != POS_QUALITY) send_byte(BYTE_W'($urandom));
		send_byte(BYTE_W'($urandom));
		send_byte({a[6:0], 1'($urandom)});
		send_byte(a[14:7]);
		send_byte(d[7:0]);
		send_byte(d[15:8]);
	endtask

	// mostly packets aimed at the next table angle, some noise and stray bytes
	task automatic send_random_packet();
		int roll;
		int span;
		int ang;
		int dist_val;
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
		end
		span = (cur_tol > 200) ? 200 : int'(cur_tol) + 2;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			ang = $urandom_range(0, ANGLE_MAX);
		else if (roll < 27)
			ang = int'(slot_angle) + ($urandom_range(0, 1) ? 1 : -1) *
				(int'(cur_tol) + int'($urandom_range(0, 1)));
		else
			ang = int'(slot_angle) + int'($urandom_range(0, 2 * span)) - span;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			dist_val = int'(cur_limit) + int'($urandom_range(0, 4)) - 2;
		else if (roll < 40)
			dist_val = roll[0] ? DIST_MAX : 0;
		else
			dist_val = $urandom_range(0, DIST_MAX);
		send_packet(ang, dist_val);
	endtask

	// one register write beat; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (idx == CFG_DIST_LIMIT) cur_limit = data;
		else if (idx == CFG_ANGLE_TOL) cur_tol = data[ANGLE_W-1:0];
	endtask

	// stop sending and wait until every result is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int                    start;
		logic [DIST_W-1:0]     lim;
		logic [CFG_DATA_W-1:0] tol;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		stream_byte = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_DIST_LIMIT;
		cfg_data    = '0;
		calm        = 1'b0;
		cur_limit   = DIST_LIMIT_RST;
		cur_tol     = ANGLE_TOL_RST;
		bytes_sent  = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: all-zero and all-one packets, exact hit at the limit,
		// hit at the window edge just past the limit, miss just outside the window
		repeat (5) send_byte('0);
		repeat (5) send_byte('1);
		send_packet(int'(slot_angle), int'(cur_limit));
		send_packet(int'(slot_angle) + int'(cur_tol), int'(cur_limit) + 1);
		send_packet(int'(slot_angle) - int'(cur_tol) - 1, DIST_MAX);
		drain();

		// random phases; each phase after the first writes a new register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				case (phase)
					1: begin lim = '0; tol = '0; end
					2: begin lim = '1; tol = '1; end
					3: begin lim = 16'd300; tol = 16'd23040; end
					4: begin
						lim = DIST_W'($urandom);
						tol = CFG_DATA_W'($urandom_range(0, 200));
					end
					5: begin lim = DIST_LIMIT_RST; tol = CFG_DATA_W'(ANGLE_TOL_RST); end
					6: begin
						lim = DIST_W'($urandom);
						tol = CFG_DATA_W'(16'h8000 | $urandom_range(0, 100));
					end
					default: begin
						lim = DIST_W'($urandom);
						tol = CFG_DATA_W'($urandom_range(0, 23040));
					end
				endcase
				write_reg(CFG_DIST_LIMIT, lim);
				// an index with no register behind it must change nothing
				write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ANGLE_TOL) + 1,
					(1 << CFG_IDX_W) - 1)), CFG_DATA_W'($urandom));
				write_reg(CFG_ANGLE_TOL, tol);
				cfg_valid <= 1'b0;
			end
			calm <= (phase == CALM_PHASE);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) send_random_packet();
			drain();
		end

		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
